[rtl/core/fsg_pkg.sv]
// Shared types and constants of the falling-sand grid step core.
`timescale 1ns / 1ps

package fsg_pkg;

	// Field widths of the command and response items and of the seed register.
	localparam int ACTION_W = 2;
	localparam int XPOS_W   = 8;
	localparam int YPOS_W   = 7;
	localparam int COUNT_W  = 15;
	localparam int SEED_W   = 16;

	typedef logic [1:0] tile_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [1:0] dir_t;

	// Tile codes.
	localparam tile_t TILE_EMPTY = 2'd0;
	localparam tile_t TILE_SAND  = 2'd1;
	localparam tile_t TILE_WALL  = 2'd2;
	localparam tile_t TILE_BAD   = 2'd3;

	// Action codes.
	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_STEP  = 2'd2;
	localparam action_t ACT_CLEAR = 2'd3;

	// Where a tile of the current grid lands in the next grid.
	localparam dir_t DIR_STAY  = 2'd0;
	localparam dir_t DIR_FALL  = 2'd1;
	localparam dir_t DIR_RIGHT = 2'd2;
	localparam dir_t DIR_LEFT  = 2'd3;

	localparam logic [SEED_W-1:0]  SEED_RESET = 16'd44257;
	localparam logic [SEED_W-1:0]  LFSR_MASK  = 16'hB400;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 15'h7FFF;

	// Outcome of the cell rule for one source tile.
	typedef struct packed {
		logic  wen;
		dir_t  dir;
		tile_t tile;
		logic  adv;
	} decision_t;

endpackage

[rtl/core/fsg_cmd_if.sv]
// Command channel carrying one grid action item.
`timescale 1ns / 1ps

interface fsg_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [fsg_pkg::ACTION_W-1:0] action;
	logic [fsg_pkg::XPOS_W-1:0]   x_pos;
	logic [fsg_pkg::YPOS_W-1:0]   y_pos;
	logic [1:0]                    tile_in;

	modport source (output valid, action, x_pos, y_pos, tile_in, input ready);
	modport sink (input valid, action, x_pos, y_pos, tile_in, output ready);
endinterface

[rtl/core/fsg_rsp_if.sv]
// Response channel carrying one result item per command.
`timescale 1ns / 1ps

interface fsg_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   tile_out;
	logic [fsg_pkg::COUNT_W-1:0] sand_count;

	modport source (output valid, tile_out, sand_count, input ready);
	modport sink (input valid, tile_out, sand_count, output ready);
endinterface

[rtl/core/falling_sand_grid_step_core.sv]
// Top level of the falling-sand grid step core: control, scan pipeline and bank swap.
`timescale 1ns / 1ps

// The core keeps a GRID_WIDTH by GRID_HEIGHT grid of 2-bit tiles (empty, sand, wall) in two
// ping-pong memory banks, one holding the current grid and one the next grid, and answers every
// command item with exactly one response item carrying the read tile and the sand count. A clear
// sweeps both banks one memory entry per cycle. In a step each cell needs three reads of the
// current bank over its two read ports, so the reads of a cell cannot all issue together, and the
// step finishes with a sweep of two columns that leaves the old bank empty for the next step.
// After reset the core runs a clearing pass over both banks and accepts no item until it is
// done. The seed register may be written at any time; it is loaded into the tie-break LFSR
// only by a clear command (a zero seed loads 1).
module falling_sand_grid_step_core #(
	parameter int GRID_WIDTH  = 192,
	parameter int GRID_HEIGHT = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fsg_pkg::SEED_W-1:0] cfg_wdata,
	fsg_cmd_if.sink                    cmd,
	fsg_rsp_if.source                  rsp
);
	import fsg_pkg::*;

	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int X_W    = $clog2(GRID_WIDTH);
	localparam int Y_W    = $clog2(GRID_HEIGHT);
	localparam int CNT_W  = $clog2(CELLS + 1);

	// Cells are stored column by column: address = x * GRID_HEIGHT + y.
	localparam logic [ADDR_W-1:0] H_STEP     = ADDR_W'(GRID_HEIGHT);
	localparam logic [ADDR_W-1:0] H2_STEP    = ADDR_W'(2 * GRID_HEIGHT);
	localparam logic [ADDR_W-1:0] COL_STEP   = ADDR_W'(2 * GRID_HEIGHT - 1);
	localparam logic [ADDR_W-1:0] ONE_A      = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] TAIL_START = ADDR_W'((GRID_WIDTH - 2) * GRID_HEIGHT);
	localparam logic [ADDR_W-1:0] SCAN_START = ADDR_W'(GRID_HEIGHT - 1);
	localparam logic [X_W-1:0]    X_LAST     = X_W'(GRID_WIDTH - 1);
	localparam logic [Y_W-1:0]    Y_LAST     = Y_W'(GRID_HEIGHT - 1);

	// Controller states.
	localparam logic [2:0] ST_SWEEP = 3'd0; // clearing pass over both banks
	localparam logic [2:0] ST_IDLE  = 3'd1; // waiting for a command item
	localparam logic [2:0] ST_RD    = 3'd2; // tile read issued for a write or read
	localparam logic [2:0] ST_EXEC  = 3'd3; // tile data back, write performed
	localparam logic [2:0] ST_SCAN  = 3'd4; // generation scan, cell by cell
	localparam logic [2:0] ST_TAIL  = 3'd5; // clearing of the last two columns
	localparam logic [2:0] ST_DONE  = 3'd6; // response waits for the output register

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              sweep_rsp_q;
	logic              cur_sel_q;
	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] lfsr_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  cnt_q;

	// Command item held while it executes.
	action_t           act_q;
	logic [ADDR_W-1:0] iaddr_q;
	logic              inside_q;
	tile_t             tin_q;
	tile_t             tile_res_q;

	// Scan position of the cell whose reads are being issued.
	logic [X_W-1:0]    sx_q;
	logic [Y_W-1:0]    sy_q;
	logic [ADDR_W-1:0] saddr_q;
	logic              ph_q;

	// Stage 1: row data of the cell to decide.
	logic              dec_v_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              bot_s1;
	logic              hr_s1;
	logic              hl_s1;
	tile_t             row_c_s1;
	tile_t             row_r_s1;

	// Row below the cell being decided, kept from the previous cell of the column.
	tile_t prev_c_q;
	tile_t prev_r_q;
	tile_t prev_l_q;

	// Stage 2: read-modify-write of the next bank.
	logic              wr_v_s2;
	logic [ADDR_W-1:0] waddr_s2;
	tile_t             wtile_s2;

	// Output register.
	logic               rsp_valid_q;
	tile_t              rsp_tile_q;
	logic [COUNT_W-1:0] rsp_count_q;

	// Memory port controls, expressed as current and next bank.
	logic              cur_we;
	logic [ADDR_W-1:0] cur_wa;
	tile_t             cur_wd;
	logic [ADDR_W-1:0] cur_ra;
	logic [ADDR_W-1:0] cur_rb;
	tile_t             cur_da;
	tile_t             cur_db;
	logic              nxt_we;
	logic [ADDR_W-1:0] nxt_wa;
	tile_t             nxt_wd;
	logic [ADDR_W-1:0] nxt_ra;
	tile_t             nxt_d;

	logic              b0_we;
	logic [ADDR_W-1:0] b0_wa;
	tile_t             b0_wd;
	logic [ADDR_W-1:0] b0_ra;
	tile_t             b0_da;
	tile_t             b0_db;
	logic              b1_we;
	logic [ADDR_W-1:0] b1_wa;
	tile_t             b1_wd;
	logic [ADDR_W-1:0] b1_ra;
	tile_t             b1_da;
	tile_t             b1_db;

	decision_t         dec;
	logic [ADDR_W-1:0] dest;
	logic              cmd_fire;
	logic              rsp_load;
	logic              in_grid;
	logic [ADDR_W-1:0] cmd_addr;
	logic [SEED_W-1:0] lfsr_adv;
	logic [SEED_W-1:0] seed_load;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.tile_out   = rsp_tile_q;
	assign rsp.sand_count = rsp_count_q;

	// Positions outside the grid are remembered as such and never reach a bank.
	assign in_grid  = (32'(cmd.x_pos) < GRID_WIDTH) && (32'(cmd.y_pos) < GRID_HEIGHT);
	assign cmd_addr = in_grid ?
		ADDR_W'(32'(cmd.x_pos) * GRID_HEIGHT + 32'(cmd.y_pos)) : '0;

	assign lfsr_adv  = {1'b0, lfsr_q[SEED_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
	assign seed_load = (seed_q == '0) ? SEED_W'(1) : seed_q;

	// Bank routing: cur_sel_q names the bank that holds the current grid.
	assign b0_we = cur_sel_q ? nxt_we : cur_we;
	assign b0_wa = cur_sel_q ? nxt_wa : cur_wa;
	assign b0_wd = cur_sel_q ? nxt_wd : cur_wd;
	assign b0_ra = cur_sel_q ? nxt_ra : cur_ra;
	assign b1_we = cur_sel_q ? cur_we : nxt_we;
	assign b1_wa = cur_sel_q ? cur_wa : nxt_wa;
	assign b1_wd = cur_sel_q ? cur_wd : nxt_wd;
	assign b1_ra = cur_sel_q ? cur_ra : nxt_ra;
	assign cur_da = cur_sel_q ? b1_da : b0_da;
	assign cur_db = cur_sel_q ? b1_db : b0_db;
	assign nxt_d  = cur_sel_q ? b0_da : b1_da;

	fsg_bank #(
		.DEPTH(CELLS)
	) u_bank0 (
		.clk    (clk),
		.we     (b0_we),
		.waddr  (b0_wa),
		.wdata  (b0_wd),
		.raddr_a(b0_ra),
		.raddr_b(cur_rb),
		.rdata_a(b0_da),
		.rdata_b(b0_db)
	);

	fsg_bank #(
		.DEPTH(CELLS)
	) u_bank1 (
		.clk    (clk),
		.we     (b1_we),
		.waddr  (b1_wa),
		.wdata  (b1_wd),
		.raddr_a(b1_ra),
		.raddr_b(cur_rb),
		.rdata_a(b1_da),
		.rdata_b(b1_db)
	);

	// The cell rule sees the source tile and the row below it, which the previous cell of the
	// same column already fetched. At the bottom row that row is stale but unused.
	fsg_rule u_rule (
		.center   (row_c_s1),
		.below    (prev_c_q),
		.right    (prev_r_q),
		.left     (prev_l_q),
		.bottom   (bot_s1),
		.has_right(hr_s1),
		.has_left (hl_s1),
		.pick     (lfsr_q[0]),
		.dec      (dec)
	);

	always_comb begin
		unique case (dec.dir)
			DIR_STAY:  dest = addr_s1;
			DIR_FALL:  dest = addr_s1 + ONE_A;
			DIR_RIGHT: dest = addr_s1 + H_STEP + ONE_A;
			DIR_LEFT:  dest = addr_s1 - H_STEP + ONE_A;
			default:   dest = addr_s1;
		endcase
	end

	// Memory port control per state. The next bank is read at the decided destination and
	// written in the next cycle with the decided tile. Decisions never come in consecutive
	// cycles, so each next bank read follows the last write-back and needs no forwarding.
	always_comb begin
		cur_we = 1'b0;
		cur_wa = sweep_q;
		cur_wd = TILE_EMPTY;
		cur_ra = saddr_q;
		cur_rb = (sx_q != X_LAST) ? saddr_q + H_STEP : saddr_q;
		nxt_we = wr_v_s2;
		nxt_wa = waddr_s2;
		nxt_wd = wtile_s2;
		nxt_ra = dest;
		unique case (state_q)
			ST_SWEEP: begin
				cur_we = 1'b1;
				nxt_we = 1'b1;
				nxt_wa = sweep_q;
				nxt_wd = TILE_EMPTY;
			end
			ST_RD: begin
				cur_ra = iaddr_q;
			end
			ST_EXEC: begin
				cur_we = (act_q == ACT_WRITE) && inside_q && (tin_q != TILE_BAD);
				cur_wa = iaddr_q;
				cur_wd = tin_q;
			end
			ST_SCAN: begin
				if (ph_q) begin
					// Second half of a cell: fetch the left neighbor and empty the
					// column two to the left, which no later cell reads again.
					cur_ra = (sx_q != '0) ? saddr_q - H_STEP : saddr_q;
					cur_we = (32'(sx_q) >= 2);
					cur_wa = saddr_q - H2_STEP;
				end
			end
			ST_TAIL: begin
				cur_we = 1'b1;
			end
			default: begin
				cur_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			sweep_rsp_q <= 1'b0;
			cur_sel_q   <= 1'b0;
			lfsr_q      <= SEED_RESET;
			total_q     <= '0;
			cnt_q       <= '0;
			ph_q        <= 1'b0;
			dec_v_s1    <= 1'b0;
			wr_v_s2     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			dec_v_s1 <= (state_q == ST_SCAN) && ph_q;
			wr_v_s2  <= dec_v_s1 && dec.wen;

			if (dec_v_s1 && dec.adv) begin
				lfsr_q <= lfsr_adv;
			end
			// A grain that lands on a cell already holding sand merges and is not counted.
			if (wr_v_s2 && (wtile_s2 == TILE_SAND) && (nxt_d != TILE_SAND)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			// The response stays valid until it is taken; a new one may load in that cycle.
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);

			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + ONE_A;
					if (sweep_q == LAST_ADDR) begin
						state_q <= sweep_rsp_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.action)
							ACT_WRITE, ACT_READ: begin
								state_q <= ST_RD;
							end
							ACT_STEP: begin
								state_q <= ST_SCAN;
								ph_q    <= 1'b0;
								cnt_q   <= '0;
							end
							ACT_CLEAR: begin
								state_q     <= ST_SWEEP;
								sweep_q     <= '0;
								sweep_rsp_q <= 1'b1;
								total_q     <= '0;
								lfsr_q      <= seed_load;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cur_we) begin
						if ((cur_da == TILE_SAND) && (tin_q != TILE_SAND)) begin
							total_q <= total_q - CNT_W'(1);
						end else if ((cur_da != TILE_SAND) && (tin_q == TILE_SAND)) begin
							total_q <= total_q + CNT_W'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					ph_q <= ~ph_q;
					if (ph_q && (sy_q == '0) && (sx_q == X_LAST)) begin
						state_q <= ST_TAIL;
						sweep_q <= TAIL_START;
					end
				end
				ST_TAIL: begin
					// The last write-back lands well before this sweep of two full columns is over.
					sweep_q <= sweep_q + ONE_A;
					if (sweep_q == LAST_ADDR) begin
						state_q   <= ST_DONE;
						total_q   <= cnt_q;
						cur_sel_q <= ~cur_sel_q;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q     <= ST_IDLE;
						sweep_rsp_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_q      <= cmd.action;
			iaddr_q    <= cmd_addr;
			inside_q   <= in_grid;
			tin_q      <= cmd.tile_in;
			tile_res_q <= TILE_EMPTY;
			sx_q       <= '0;
			sy_q       <= Y_LAST;
			saddr_q    <= SCAN_START;
		end
		if (state_q == ST_EXEC) begin
			tile_res_q <= ((act_q == ACT_READ) && inside_q) ? cur_da : TILE_EMPTY;
		end
		if ((state_q == ST_SCAN) && ph_q) begin
			// Row data of this cell arrived; step up the column, or to the bottom of
			// the next column.
			row_c_s1 <= cur_da;
			row_r_s1 <= cur_db;
			addr_s1  <= saddr_q;
			bot_s1   <= (sy_q == Y_LAST);
			hr_s1    <= (sx_q != X_LAST);
			hl_s1    <= (sx_q != '0);
			if (sy_q == '0) begin
				sx_q    <= sx_q + X_W'(1);
				sy_q    <= Y_LAST;
				saddr_q <= saddr_q + COL_STEP;
			end else begin
				sy_q    <= sy_q - Y_W'(1);
				saddr_q <= saddr_q - ONE_A;
			end
		end
		if (dec_v_s1) begin
			prev_c_q <= row_c_s1;
			prev_r_q <= row_r_s1;
			prev_l_q <= cur_da;
			waddr_s2 <= dest;
			wtile_s2 <= dec.tile;
		end
		if (rsp_load) begin
			rsp_tile_q  <= tile_res_q;
			rsp_count_q <= (32'(total_q) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(total_q);
		end
	end

	// Write-backs to the next bank happen only while a step is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s2 |-> ((state_q == ST_SCAN) || (state_q == ST_TAIL)))
		else $error("next bank write-back outside a step");

	// Two read-modify-writes of the next bank never overlap.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s2 |-> !dec_v_s1)
		else $error("overlapping next bank read-modify-write");

	// A decision is taken only right after the second half of a scanned cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		dec_v_s1 |-> $past((state_q == ST_SCAN) && ph_q))
		else $error("cell decision without fetched row data");

	// No bank is ever written with the unused tile code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_we |-> (cur_wd != TILE_BAD)) and (nxt_we |-> (nxt_wd != TILE_BAD)))
		else $error("unused tile code written to a bank");

	// The sand count of a step cannot exceed the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) <= CELLS))
		else $error("step sand count beyond grid size");

endmodule

[rtl/core/fsg_bank.sv]
// Grid tile memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module fsg_bank #(
	parameter int DEPTH = 24576
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  fsg_pkg::tile_t           wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output fsg_pkg::tile_t           rdata_a,
	output fsg_pkg::tile_t           rdata_b
);
	import fsg_pkg::*;

	tile_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/core/fsg_rule.sv]
// Falling-sand cell rule: decides where one source tile lands in the next grid.
`timescale 1ns / 1ps

module fsg_rule (
	input  fsg_pkg::tile_t     center,
	input  fsg_pkg::tile_t     below,
	input  fsg_pkg::tile_t     right,
	input  fsg_pkg::tile_t     left,
	input  logic               bottom,
	input  logic               has_right,
	input  logic               has_left,
	input  logic               pick,
	output fsg_pkg::decision_t dec
);
	import fsg_pkg::*;

	logic rc;
	logic lc;

	assign rc = has_right && (right == TILE_EMPTY);
	assign lc = has_left && (left == TILE_EMPTY);

	always_comb begin
		dec = '{wen: 1'b0, dir: DIR_STAY, tile: TILE_EMPTY, adv: 1'b0};
		priority if (center == TILE_WALL) begin
			dec.wen  = 1'b1;
			dec.tile = TILE_WALL;
		end else if (center == TILE_SAND) begin
			dec.wen  = 1'b1;
			dec.tile = TILE_SAND;
			priority if (bottom) begin
				dec.dir = DIR_STAY;
			end else if (below == TILE_EMPTY) begin
				dec.dir = DIR_FALL;
			end else if (below == TILE_WALL) begin
				dec.dir = DIR_STAY;
			end else if (rc && lc) begin
				// Both diagonals free: the low LFSR bit breaks the tie.
				dec.adv = 1'b1;
				dec.dir = pick ? DIR_LEFT : DIR_RIGHT;
			end else if (rc) begin
				dec.dir = DIR_RIGHT;
			end else if (lc) begin
				dec.dir = DIR_LEFT;
			end else begin
				dec.dir = DIR_STAY;
			end
		end else begin
			dec.wen = 1'b0;
		end
	end

endmodule

[tb/tb_falling_sand_grid_step_core.sv]
// Self-checking testbench of the falling-sand grid step core with a built-in grid predictor.
`timescale 1ns / 1ps

module tb_falling_sand_grid_step_core;

	import fsg_pkg::*;

	localparam int GRID_W      = 192;
	localparam int GRID_H      = 128;
	localparam int GRID_CELLS  = GRID_W * GRID_H;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int STALL_PCT   = 8;
	localparam int TAIL_CYCLES = 20;

	// One command item as it goes out on the command channel.
	typedef struct {
		action_t            action;
		logic [XPOS_W-1:0]  x;
		logic [YPOS_W-1:0]  y;
		tile_t              tile;
	} grid_cmd_t;

	// One response item as the predictor expects it.
	typedef struct {
		tile_t              tile;
		logic [COUNT_W-1:0] count;
	} grid_rsp_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [SEED_W-1:0]  cfg_wdata;

	fsg_cmd_if cmd_ch ();
	fsg_rsp_if rsp_ch ();

	falling_sand_grid_step_core #(
		.GRID_WIDTH (GRID_W),
		.GRID_HEIGHT(GRID_H)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	// The clock runs with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predicted state of the block: the current grid, the scratch grid that a generation is
	// built into, the tie-break LFSR, the seed register and the running sand total.
	tile_t             grid_now  [GRID_CELLS];
	tile_t             grid_next [GRID_CELLS];
	logic [SEED_W-1:0] lfsr_now;
	logic [SEED_W-1:0] seed_now;
	int unsigned       sand_now;

	// Items waiting to be sent and responses waiting to arrive, oldest first.
	grid_cmd_t cmd_queue[$];
	grid_rsp_t expected_rsp[$];
	grid_cmd_t accepted_cmd;
	grid_cmd_t next_cmd;
	grid_rsp_t oldest_rsp;

	// When set, neither side stalls; this gives one long stretch at full rate.
	bit no_stall;

	int fail_count;
	int cycle_count;
	int writes_sent;
	int reads_sent;
	int generations_sent;
	int clears_sent;
	int responses_seen;

	function automatic int cell_idx(int x, int y);
		return x * GRID_H + y;
	endfunction

	// The clear action reloads the LFSR from the seed register; a zero seed would lock the
	// LFSR, so the value 1 goes in instead.
	function automatic void wipe_grid();
		foreach (grid_now[i]) grid_now[i] = TILE_EMPTY;
		foreach (grid_next[i]) grid_next[i] = TILE_EMPTY;
		sand_now = 0;
		lfsr_now = (seed_now == '0) ? SEED_W'(1) : seed_now;
	endfunction

	// One generation. The scan goes column by column with x rising and, within a column,
	// from the bottom row upward. Every decision looks only at the current grid and writes
	// into the cleared next grid, so two grains landing on one cell merge into one.
	function automatic void advance_generation();
		tile_t here;
		tile_t below;
		bit    right_free;
		bit    left_free;
		bit    tie_bit;
		foreach (grid_next[i]) grid_next[i] = TILE_EMPTY;
		for (int x = 0; x < GRID_W; x++) begin
			for (int y = GRID_H - 1; y >= 0; y--) begin
				here = grid_now[cell_idx(x, y)];
				if (here == TILE_WALL) begin
					grid_next[cell_idx(x, y)] = TILE_WALL;
				end else if (here == TILE_SAND) begin
					if (y == GRID_H - 1) begin
						grid_next[cell_idx(x, y)] = TILE_SAND;
					end else begin
						below = grid_now[cell_idx(x, y + 1)];
						if (below == TILE_EMPTY) begin
							grid_next[cell_idx(x, y + 1)] = TILE_SAND;
						end else if (below == TILE_WALL) begin
							grid_next[cell_idx(x, y)] = TILE_SAND;
						end else begin
							right_free = (x + 1 < GRID_W) &&
								(grid_now[cell_idx(x + 1, y + 1)] == TILE_EMPTY);
							left_free = (x > 0) &&
								(grid_now[cell_idx(x - 1, y + 1)] == TILE_EMPTY);
							if (right_free && left_free) begin
								// Both sides open: the LFSR low bit picks, 0 for right.
								tie_bit = lfsr_now[0];
								lfsr_now = (lfsr_now >> 1) ^ (tie_bit ? LFSR_MASK : '0);
								if (!tie_bit) begin
									grid_next[cell_idx(x + 1, y + 1)] = TILE_SAND;
								end else begin
									grid_next[cell_idx(x - 1, y + 1)] = TILE_SAND;
								end
							end else if (right_free) begin
								grid_next[cell_idx(x + 1, y + 1)] = TILE_SAND;
							end else if (left_free) begin
								grid_next[cell_idx(x - 1, y + 1)] = TILE_SAND;
							end else begin
								grid_next[cell_idx(x, y)] = TILE_SAND;
							end
						end
					end
				end
			end
		end
		sand_now = 0;
		foreach (grid_now[i]) begin
			grid_now[i] = grid_next[i];
			if (grid_next[i] == TILE_SAND) sand_now++;
		end
	endfunction

	// Applies one accepted item to the predicted state and returns the response it causes.
	// Writes off the grid and writes of the unused tile code leave the grid untouched.
	function automatic grid_rsp_t predict_grid_rsp(grid_cmd_t c);
		grid_rsp_t r;
		bit        on_grid;
		int        idx;
		r.tile = TILE_EMPTY;
		on_grid = (int'(c.x) < GRID_W) && (int'(c.y) < GRID_H);
		idx = on_grid ? cell_idx(int'(c.x), int'(c.y)) : 0;
		case (c.action)
			ACT_WRITE: begin
				if (on_grid && c.tile != TILE_BAD) begin
					if (grid_now[idx] == TILE_SAND) sand_now--;
					grid_now[idx] = c.tile;
					if (c.tile == TILE_SAND) sand_now++;
				end
			end
			ACT_READ: begin
				if (on_grid) r.tile = grid_now[idx];
			end
			ACT_STEP: begin
				advance_generation();
			end
			default: begin
				wipe_grid();
			end
		endcase
		r.count = (sand_now > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(sand_now);
		return r;
	endfunction

	task automatic report_error(string msg);
		fail_count++;
		if (fail_count <= 10) $display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic queue_cmd(action_t a, int x, int y, tile_t t);
		grid_cmd_t c;
		c.action = a;
		c.x = XPOS_W'(x);
		c.y = YPOS_W'(y);
		c.tile = t;
		cmd_queue.push_back(c);
	endtask

	// A cluster of writes in a small window, one generation, then reads of the window. The
	// window is dense enough that grains land on grains, on walls and on each other's paths,
	// and it sits at the grid edges or on the bottom row often. A few writes go off the grid
	// or use the unused tile code, and some reads go anywhere.
	task automatic queue_sand_cluster();
		int spot;
		int bx;
		int by;
		int roll;
		tile_t t;
		spot = $urandom_range(0, 3);
		bx = (spot == 0) ? 0 : (spot == 1) ? GRID_W - 6 : $urandom_range(0, GRID_W - 6);
		by = ($urandom_range(0, 99) < 40) ? GRID_H - 4 : $urandom_range(0, GRID_H - 4);
		repeat (9) begin
			roll = $urandom_range(0, 99);
			t = (roll < 60) ? TILE_SAND : (roll < 82) ? TILE_WALL :
				(roll < 94) ? TILE_EMPTY : TILE_BAD;
			if ($urandom_range(0, 99) < 6) begin
				queue_cmd(ACT_WRITE, $urandom_range(GRID_W, 255), $urandom_range(0, GRID_H - 1), t);
			end else begin
				queue_cmd(ACT_WRITE, bx + $urandom_range(0, 5), by + $urandom_range(0, 3), t);
			end
		end
		queue_cmd(ACT_STEP, $urandom_range(0, 255), $urandom_range(0, 127),
			tile_t'($urandom_range(0, 3)));
		repeat (4) begin
			if ($urandom_range(0, 99) < 25) begin
				queue_cmd(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 127),
					tile_t'($urandom_range(0, 3)));
			end else begin
				queue_cmd(ACT_READ, bx + $urandom_range(0, 5), by + $urandom_range(0, 3),
					tile_t'($urandom_range(0, 3)));
			end
		end
	endtask

	// Waits until nothing is queued, nothing is on the command channel and every expected
	// response has arrived. It samples at the falling edge so that it never races the
	// clocked driver and monitor.
	task automatic wait_quiet();
		@(negedge clk);
		while (cmd_queue.size() != 0 || cmd_ch.valid || expected_rsp.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// The seed register only matters at the next clear; the predictor follows the same rule
	// because its LFSR is loaded from seed_now only in wipe_grid.
	task automatic write_seed(logic [SEED_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		seed_now = value;
		@(negedge clk);
	endtask

	// Command driver. At each rising edge it first takes note of an item that the block has
	// just accepted and runs it through the predictor, then puts the next queued item on the
	// channel when the slot is free. Valid gets at most one assignment per edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				accepted_cmd.action = cmd_ch.action;
				accepted_cmd.x = cmd_ch.x_pos;
				accepted_cmd.y = cmd_ch.y_pos;
				accepted_cmd.tile = cmd_ch.tile_in;
				expected_rsp.push_back(predict_grid_rsp(accepted_cmd));
				case (accepted_cmd.action)
					ACT_WRITE: writes_sent++;
					ACT_READ: reads_sent++;
					ACT_STEP: generations_sent++;
					default: clears_sent++;
				endcase
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_queue.size() != 0 &&
					(no_stall || $urandom_range(0, 99) >= STALL_PCT)) begin
					next_cmd = cmd_queue.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.action <= next_cmd.action;
					cmd_ch.x_pos <= next_cmd.x;
					cmd_ch.y_pos <= next_cmd.y;
					cmd_ch.tile_in <= next_cmd.tile;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor. Each accepted response is checked field by field against the oldest
	// expectation; the ready line stalls at random except in the full-rate stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				responses_seen++;
				if (expected_rsp.size() == 0) begin
					report_error($sformatf("response with none expected: tile %0d count %0d",
						rsp_ch.tile_out, rsp_ch.sand_count));
				end else begin
					oldest_rsp = expected_rsp.pop_front();
					if (rsp_ch.tile_out !== oldest_rsp.tile) begin
						report_error($sformatf("tile_out expected %0d, got %0d",
							oldest_rsp.tile, rsp_ch.tile_out));
					end
					if (rsp_ch.sand_count !== oldest_rsp.count) begin
						report_error($sformatf("sand_count expected %0d, got %0d",
							oldest_rsp.count, rsp_ch.sand_count));
					end
				end
			end
			rsp_ch.ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// Watchdog: the slowest correct run is well below this limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_count, expected_rsp.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// Every input of the block has a known value from time zero.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_WRITE;
		cmd_ch.x_pos = '0;
		cmd_ch.y_pos = '0;
		cmd_ch.tile_in = TILE_EMPTY;
		rsp_ch.ready = 1'b0;
		no_stall = 1'b0;
		seed_now = SEED_RESET;
		wipe_grid();

		// Directed part with the reset seed. It covers the field extremes, every action,
		// writes off the grid and of the unused tile code, and one example of each sand rule:
		// falling, resting on a wall, a tie between both diagonals, right only at the left
		// edge, left only at the right edge, and grains on the bottom row.
		queue_cmd(ACT_READ, 0, 0, TILE_EMPTY);
		queue_cmd(ACT_WRITE, 0, GRID_H - 1, TILE_SAND);
		queue_cmd(ACT_WRITE, GRID_W - 1, 0, TILE_WALL);
		queue_cmd(ACT_WRITE, GRID_W - 1, GRID_H - 1, TILE_SAND);
		queue_cmd(ACT_WRITE, GRID_W, 10, TILE_SAND);
		queue_cmd(ACT_WRITE, 255, GRID_H - 1, TILE_WALL);
		queue_cmd(ACT_WRITE, 0, GRID_H - 1, TILE_BAD);
		queue_cmd(ACT_READ, 0, GRID_H - 1, TILE_BAD);
		queue_cmd(ACT_READ, 200, 3, TILE_SAND);
		queue_cmd(ACT_WRITE, 20, 50, TILE_SAND);
		queue_cmd(ACT_WRITE, 30, 60, TILE_SAND);
		queue_cmd(ACT_WRITE, 30, 61, TILE_WALL);
		queue_cmd(ACT_WRITE, 40, 100, TILE_SAND);
		queue_cmd(ACT_WRITE, 40, 101, TILE_SAND);
		queue_cmd(ACT_WRITE, 0, 100, TILE_SAND);
		queue_cmd(ACT_WRITE, 0, 101, TILE_SAND);
		queue_cmd(ACT_WRITE, GRID_W - 1, 90, TILE_SAND);
		queue_cmd(ACT_WRITE, GRID_W - 1, 91, TILE_SAND);
		queue_cmd(ACT_STEP, 255, 127, TILE_BAD);
		queue_cmd(ACT_READ, 20, 51, TILE_EMPTY);
		queue_cmd(ACT_READ, 40, 102, TILE_EMPTY);
		queue_cmd(ACT_WRITE, 20, 51, TILE_EMPTY);
		queue_cmd(ACT_WRITE, 0, GRID_H - 1, TILE_WALL);
		queue_cmd(ACT_STEP, 0, 0, TILE_EMPTY);
		queue_cmd(ACT_CLEAR, 128, 64, TILE_WALL);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// A zero seed is written but only the clear that follows loads it. The cluster in
		// between still runs on the LFSR of the earlier clear.
		wait_quiet();
		write_seed('0);
		queue_sand_cluster();
		queue_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
			tile_t'($urandom_range(0, 3)));
		queue_sand_cluster();

		// Highest seed. The second cluster runs with no stalls on either side, after the
		// sender has held back until every expected response was in.
		wait_quiet();
		write_seed(16'hFFFF);
		queue_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
			tile_t'($urandom_range(0, 3)));
		queue_sand_cluster();
		wait_quiet();
		no_stall = 1'b1;
		queue_sand_cluster();
		wait_quiet();
		no_stall = 1'b0;

		// Lowest seed.
		write_seed(16'd1);
		queue_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
			tile_t'($urandom_range(0, 3)));
		queue_sand_cluster();

		// A random seed, with two clusters so grains from the first are still around.
		wait_quiet();
		write_seed(SEED_W'($urandom_range(1, 65535)));
		queue_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127),
			tile_t'($urandom_range(0, 3)));
		queue_sand_cluster();
		queue_sand_cluster();

		// Let everything drain, then leave room for any stray response.
		wait_quiet();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Ran %0d writes, %0d reads, %0d generations and %0d clears; %0d responses.",
			writes_sent, reads_sent, generations_sent, clears_sent, responses_seen);
		$display("Seeds: reset value, zero, 1, 65535 and one random; %0d errors in %0d cycles.",
			fail_count, cycle_count);
		if (fail_count == 0 && expected_rsp.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
